// ===== rtl/mfb_pkg.sv =====
// Shared constants, request codes and inter-module types of the monochrome
// frame buffer pixel and line engine. No dependencies.
`default_nettype none

package mfb_pkg;

  localparam int SCREEN_WIDTH  = 84;
  localparam int SCREEN_HEIGHT = 48;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  // Wide enough for page * SCREEN_WIDTH + x and for STORE_BYTES itself.
  localparam int CALC_W        = 16;

  localparam logic [2:0] REQ_SET_PIX   = 3'd0;
  localparam logic [2:0] REQ_CLR_PIX   = 3'd1;
  localparam logic [2:0] REQ_INV_PIX   = 3'd2;
  localparam logic [2:0] REQ_DRAW_LINE = 3'd3;
  localparam logic [2:0] REQ_CLR_LINE  = 3'd4;
  localparam logic [2:0] REQ_READ_BYTE = 3'd5;

  typedef struct packed {
    logic load;
    logic adv;
  } mfb_step_ctl_t;

  typedef struct packed {
    logic [7:0] cx;
    logic [7:0] cy;
    logic       last;
  } mfb_step_sts_t;

endpackage

`default_nettype wire

// ===== rtl/mfb_ifs.sv =====
// Valid/ready channel interfaces for requests and results of the frame
// buffer engine. No dependencies.
`default_nettype none

interface mfb_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] x_start;
  logic [7:0] y_start;
  logic [7:0] x_end;
  logic [7:0] y_end;
  logic [8:0] byte_index;

  modport source (output valid, req_type, x_start, y_start, x_end, y_end, byte_index,
                  input ready);
  modport sink (input valid, req_type, x_start, y_start, x_end, y_end, byte_index,
                output ready);
endinterface

interface mfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [2:0] done_type;

  modport source (output valid, read_data, done_type, input ready);
  modport sink (input valid, read_data, done_type, output ready);
endinterface

`default_nettype wire

// ===== rtl/mfb_frame_ram.sv =====
// Frame store: one write port and one registered read port.
// Depends on mfb_pkg for the store size.
`default_nettype none

module mfb_frame_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [mfb_pkg::ADDR_W-1:0] waddr,
  input  wire logic [7:0]                wdata,
  input  wire logic                      re,
  input  wire logic [mfb_pkg::ADDR_W-1:0] raddr,
  output logic      [7:0]                rdata
);
  import mfb_pkg::*;

  logic [7:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mfb_line_stepper.sv =====
// Line stepper: per-axis error accumulators that advance the current point
// by one plotted point per advance strobe. Depends on mfb_pkg.
`default_nettype none

module mfb_line_stepper (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mfb_pkg::mfb_step_ctl_t ctl,
  input  wire logic [7:0]             x_start,
  input  wire logic [7:0]             y_start,
  input  wire logic [7:0]             x_end,
  input  wire logic [7:0]             y_end,
  output mfb_pkg::mfb_step_sts_t      sts
);
  import mfb_pkg::*;

  logic [7:0] cx_r, cy_r, dx_r, dy_r, dist_r, step_x_r, step_y_r;
  logic [8:0] err_x_r, err_y_r, cnt_r;

  logic [7:0] ld_dx, ld_dy, ld_sx, ld_sy, ld_dist;
  logic [8:0] ex_sum, ey_sum;

  always_comb begin
    if (x_end > x_start) begin
      ld_dx = x_end - x_start;
      ld_sx = 8'h01;
    end else begin
      ld_dx = x_start - x_end;
      ld_sx = (x_end == x_start) ? 8'h00 : 8'hFF;
    end
    if (y_end > y_start) begin
      ld_dy = y_end - y_start;
      ld_sy = 8'h01;
    end else begin
      ld_dy = y_start - y_end;
      ld_sy = (y_end == y_start) ? 8'h00 : 8'hFF;
    end
    ld_dist = (ld_dx > ld_dy) ? ld_dx : ld_dy;
    ex_sum  = err_x_r + {1'b0, dx_r};
    ey_sum  = err_y_r + {1'b0, dy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      err_x_r  <= '0;
      err_y_r  <= '0;
      step_x_r <= '0;
      step_y_r <= '0;
    end else if (ctl.load) begin
      cx_r     <= x_start;
      cy_r     <= y_start;
      dx_r     <= ld_dx;
      dy_r     <= ld_dy;
      dist_r   <= ld_dist;
      step_x_r <= ld_sx;
      step_y_r <= ld_sy;
      err_x_r  <= '0;
      err_y_r  <= '0;
      // Remaining points after the current one: the line plots dist + 2.
      cnt_r    <= {1'b0, ld_dist} + 9'd1;
    end else if (ctl.adv) begin
      if (ex_sum > {1'b0, dist_r}) begin
        err_x_r <= ex_sum - {1'b0, dist_r};
        cx_r    <= cx_r + step_x_r;
      end else begin
        err_x_r <= ex_sum;
      end
      if (ey_sum > {1'b0, dist_r}) begin
        err_y_r <= ey_sum - {1'b0, dist_r};
        cy_r    <= cy_r + step_y_r;
      end else begin
        err_y_r <= ey_sum;
      end
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 9'd1;
      end
    end
  end

  assign sts.cx   = cx_r;
  assign sts.cy   = cy_r;
  assign sts.last = (cnt_r == '0);

endmodule

`default_nettype wire

// ===== rtl/mono_framebuffer_pixel_line_engine_core.sv =====
// Top level of the frame buffer pixel and line engine: command sequencer,
// read-modify-write path and result register. Depends on mfb_pkg, mfb_ifs,
// mfb_frame_ram and mfb_line_stepper.
//
// After reset the engine zeroes all 504 bytes of the frame store, one byte
// per cycle, with in_req.ready low. Each plotted point is a read-modify-write
// of one store byte, and the store's read port is registered, so a point is
// read in ST_PT_RD and written back in ST_PT_WR. A set, clear or invert pixel
// transaction passes through ST_PT_RD, ST_PT_WR and ST_DONE, a read byte
// through ST_RB_RD and ST_DONE, an unknown request code straight to ST_DONE,
// and a line repeats ST_PT_RD and ST_PT_WR for each of its max(|dx|, |dy|) + 2
// points before ST_DONE. Only one transaction is worked on at a time; a
// finished result sits in the output register, so the next transaction may be
// accepted before the previous result is taken. A result that finds the output
// register still full waits in ST_DONE until out_rsp.ready is high.
`default_nettype none

module mono_framebuffer_pixel_line_engine_core (
  input  wire logic clk,
  input  wire logic rst_n,
  mfb_req_if.sink   in_req,
  mfb_rsp_if.source out_rsp
);
  import mfb_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PT_RD, ST_PT_WR, ST_RB_RD, ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [2:0]        req_r, req_nxt;
  logic [7:0]        px_r, px_nxt, py_r, py_nxt;
  logic [8:0]        idx_r, idx_nxt;
  logic              is_line_r, is_line_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic              on_r, on_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic [2:0]        out_type_r, out_type_nxt;

  logic              accept;
  logic              req_is_line;
  logic [7:0]        cur_x, cur_y;
  logic [CALC_W-1:0] addr_full;
  logic              cur_on;
  logic              idx_ok;
  logic [7:0]        new_byte;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  mfb_step_ctl_t     step_ctl;
  mfb_step_sts_t     step_sts;

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign req_is_line  = (in_req.req_type == REQ_DRAW_LINE) ||
                        (in_req.req_type == REQ_CLR_LINE);

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.read_data = out_data_r;
  assign out_rsp.done_type = out_type_r;

  mfb_line_stepper u_stepper (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (step_ctl),
    .x_start (in_req.x_start),
    .y_start (in_req.y_start),
    .x_end   (in_req.x_end),
    .y_end   (in_req.y_end),
    .sts     (step_sts)
  );

  mfb_frame_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Address and on-screen check of the point being plotted, and range check of the read byte index.
  always_comb begin
    cur_x     = is_line_r ? step_sts.cx : px_r;
    cur_y     = is_line_r ? step_sts.cy : py_r;
    addr_full = CALC_W'(cur_y[7:3]) * CALC_W'(SCREEN_WIDTH) + CALC_W'(cur_x);
    cur_on    = (cur_x < 8'(SCREEN_WIDTH)) && (cur_y < 8'(SCREEN_HEIGHT)) &&
                (addr_full < CALC_W'(STORE_BYTES));
    idx_ok    = CALC_W'(idx_r) < CALC_W'(STORE_BYTES);
  end

  always_comb begin
    case (req_r)
      REQ_SET_PIX, REQ_DRAW_LINE: new_byte = ram_rdata | mask_r;
      REQ_CLR_PIX, REQ_CLR_LINE:  new_byte = ram_rdata & ~mask_r;
      default:                    new_byte = ram_rdata ^ mask_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    req_nxt       = req_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    idx_nxt       = idx_r;
    is_line_nxt   = is_line_r;
    addr_nxt      = addr_r;
    mask_nxt      = mask_r;
    on_nxt        = on_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_type_nxt  = out_type_r;
    step_ctl      = '0;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = new_byte;
    ram_re        = 1'b0;
    ram_raddr     = ADDR_W'(addr_full);

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == ADDR_W'(STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_nxt       = in_req.req_type;
          px_nxt        = in_req.x_start;
          py_nxt        = in_req.y_start;
          idx_nxt       = in_req.byte_index;
          is_line_nxt   = req_is_line;
          step_ctl.load = req_is_line;
          case (in_req.req_type)
            REQ_SET_PIX, REQ_CLR_PIX, REQ_INV_PIX,
            REQ_DRAW_LINE, REQ_CLR_LINE: state_nxt = ST_PT_RD;
            REQ_READ_BYTE:               state_nxt = ST_RB_RD;
            default:                     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PT_RD: begin
        ram_re    = cur_on;
        addr_nxt  = ADDR_W'(addr_full);
        mask_nxt  = 8'd1 << cur_y[2:0];
        on_nxt    = cur_on;
        state_nxt = ST_PT_WR;
      end
      ST_PT_WR: begin
        ram_we       = on_r;
        step_ctl.adv = is_line_r;
        if (is_line_r && !step_sts.last) begin
          state_nxt = ST_PT_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RB_RD: begin
        ram_re    = idx_ok;
        ram_raddr = ADDR_W'(idx_r);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_type_nxt  = req_r;
          out_data_nxt  = ((req_r == REQ_READ_BYTE) && idx_ok) ? ram_rdata : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      is_line_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      is_line_r   <= is_line_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    idx_r      <= idx_nxt;
    addr_r     <= addr_nxt;
    mask_r     <= mask_nxt;
    on_r       <= on_nxt;
    out_data_r <= out_data_nxt;
    out_type_r <= out_type_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/mfb_checker.sv =====
// Port-level checks for the frame buffer engine, bound to the top level.
// Depends on mfb_pkg for request codes.
`default_nettype none

module mfb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_data,
  input wire logic [2:0] done_type
);
  import mfb_pkg::*;

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(done_type))
    else $error("result changed while stalled");

  // The engine works on one transaction at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a transaction is in progress");

  // Only a read returns data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (done_type != REQ_READ_BYTE) |-> read_data == 8'd0)
    else $error("nonzero data on a non-read result");

  // The store clearing pass keeps requests out right after reset.
  assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("engine ready during store clearing");

endmodule

bind mono_framebuffer_pixel_line_engine_core mfb_checker u_mfb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .read_data (out_rsp.read_data),
  .done_type (out_rsp.done_type)
);

`default_nettype wire
